// ===== rtl/core/windowed_read_duplicate_detector_defines.svh =====
// Assertion macros used by the back end of the windowed read duplicate detector.
`ifndef WINDOWED_READ_DUPLICATE_DETECTOR_DEFINES_SVH
`define WINDOWED_READ_DUPLICATE_DETECTOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WRDD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrdd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define WRDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrdd assertion failed");

`endif

// ===== rtl/core/wrdd_pkg.sv =====
// Types, constants and helper functions of the windowed read duplicate detector.
`default_nettype none

package wrdd_pkg;

    localparam int BUCKET_BITS   = 12;
    localparam int WAYS          = 4;
    localparam int MAX_KEY_WORDS = 2;
    localparam int COORD_BITS    = 20;

    localparam int UNK_WORDS   = (MAX_KEY_WORDS + 1) / 2;
    localparam int BUCKETS     = 1 << BUCKET_BITS;
    localparam int BLOCK_LIMIT = 4 * MAX_KEY_WORDS;
    localparam int BC_W        = $clog2(BLOCK_LIMIT + 1) < 3 ? 3 : $clog2(BLOCK_LIMIT + 1);
    localparam int WI_W        = BC_W - 2;
    localparam int KW_W        = 2;
    localparam int AGE_W       = $clog2(WAYS + 1);
    localparam int REGION_W    = 15;
    localparam int COUNT_W     = 40;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH) < 1 ? 1 : $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [63:0] CODE_MASK = 64'h0606060606060606;
    localparam logic [63:0] UNK_MASK  = 64'h0808080808080808;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS = 2'd3;

    localparam logic [1:0] ORDER_SORTED = 2'd0;
    localparam logic [1:0] ORDER_REGION = 2'd1;

    typedef struct packed {
        logic [63:0]           char_block;
        logic                  last_block;
        logic [REGION_W-1:0]   region_id;
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
    } t_in;

    typedef struct packed {
        logic               duplicate_found;
        logic               bucket_overflow;
        logic [COUNT_W-1:0] read_total;
        logic [COUNT_W-1:0] duplicate_total;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] window_x;
        logic [COORD_BITS-1:0] window_y;
        logic [1:0]            order_mode;
        logic [KW_W-1:0]       key_words;
    } t_cfg;

    typedef struct packed {
        logic [BUCKET_BITS-1:0]                 bucket;
        logic [REGION_W-1:0]                    region;
        logic [COORD_BITS-1:0]                  x;
        logic [COORD_BITS-1:0]                  y;
        logic [MAX_KEY_WORDS-1:0][63:0]         code;
        logic [UNK_WORDS-1:0][63:0]             flags;
    } t_job;

    typedef struct packed {
        logic                           valid;
        logic [AGE_W-1:0]               age;
        logic [REGION_W-1:0]            region;
        logic [COORD_BITS-1:0]          x;
        logic [COORD_BITS-1:0]          y;
        logic [MAX_KEY_WORDS-1:0][63:0] code;
        logic [UNK_WORDS-1:0][63:0]     flags;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    function automatic logic [KW_W-1:0] eff_words(input logic [KW_W-1:0] kw);
        logic [KW_W-1:0] r;
        r = kw;
        if (kw == '0) begin
            r = KW_W'(1);
        end else if (int'(kw) > MAX_KEY_WORDS) begin
            r = KW_W'(MAX_KEY_WORDS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/windowed_read_duplicate_detector.sv =====
// Top level of the windowed read duplicate detector with its configuration registers.
//
// Usage: a read enters as a run of transfers on the input channel, one 64-bit block
// of eight ASCII characters per transfer; the transfer with last_block set also carries
// region, x and y. Each last block produces exactly one result transfer on the output
// channel; other blocks produce none. Configuration registers are written through the
// configuration channel, which is always ready; the user must write them only
// while no read is in flight, and the block itself does not enforce this. Blocks
// are taken one per cycle while the input channel is ready. After a last block
// the back end updates the bucket by row read, compare and write back, and pops
// the next read only after write back. A two-entry queue lets the front keep
// assembling the next read meanwhile. After reset the bucket memory is cleared
// one row a cycle over all 4096 rows, while the input channel is not ready. When
// the receiver stalls, the result is held in the output register, the back end
// waits at write back, and once the queue fills the input channel deasserts ready.
`default_nettype none

module windowed_read_duplicate_detector
    import wrdd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job push_job, head_job;
    logic push, q_ready, q_valid, q_pop, run;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_x   <= COORD_BITS'(2500);
            r_cfg.window_y   <= COORD_BITS'(2500);
            r_cfg.order_mode <= ORDER_SORTED;
            r_cfg.key_words  <= KW_W'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_X:  r_cfg.window_x   <= i_cfg_data[COORD_BITS-1:0];
                CFG_WINDOW_Y:  r_cfg.window_y   <= i_cfg_data[COORD_BITS-1:0];
                CFG_ORDER:     r_cfg.order_mode <= i_cfg_data[1:0];
                CFG_KEY_WORDS: r_cfg.key_words  <= i_cfg_data[KW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wrdd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_run      (run),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_q_ready  (q_ready)
    );

    wrdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    wrdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .o_run       (run),
        .i_q_valid   (q_valid),
        .i_q_job     (head_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/wrdd_front.sv =====
// Block assembly, base packing and bucket hashing of incoming reads.
`default_nettype none

module wrdd_front
    import wrdd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_run,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_push,
    output t_job      o_job,
    input  wire logic i_q_ready
);

    logic [MAX_KEY_WORDS-1:0][63:0] r_code, n_code;
    logic [UNK_WORDS-1:0][63:0]     r_flag, n_flag;
    logic [BC_W-1:0]                r_bc;
    logic [WI_W-1:0]                w;
    logic [1:0]                     k;
    logic [2:0]                     p;
    logic [3:0]                     shamt;
    logic [KW_W-1:0]                kw;
    logic                           take;
    logic                           accept;
    logic [63:0]                    d, nb, sum;

    assign o_in_ready = i_q_ready && i_run;
    assign accept     = i_in_valid && o_in_ready;
    assign kw         = eff_words(i_cfg.key_words);
    assign w          = r_bc[BC_W-1:2];
    assign k          = r_bc[1:0];
    assign p          = {w[0], k};
    assign shamt      = {1'b0, k, 1'b0} - 4'd1;
    assign take       = (int'(r_bc) < BLOCK_LIMIT) && (int'(w) < int'(kw));
    assign d          = i_in_data.char_block & CODE_MASK;
    assign nb         = i_in_data.char_block & UNK_MASK;

    always_comb begin
        n_code = r_code;
        n_flag = r_flag;
        sum    = '0;
        for (int i = 0; i < MAX_KEY_WORDS; i++) begin
            if (take && int'(w) == i) begin
                n_code[i] = r_code[i] | ((k == 2'd0) ? (d >> 1) : (d << shamt));
            end
        end
        for (int i = 0; i < UNK_WORDS; i++) begin
            if (take && int'(w >> 1) == i) begin
                n_flag[i] = r_flag[i] | ((p < 3'd3) ? (nb >> (3'd3 - p)) : (nb << (p - 3'd3)));
            end
        end
        for (int i = 0; i < MAX_KEY_WORDS; i++) begin
            if (i < int'(kw)) begin
                sum = sum + n_code[i];
            end
        end
    end

    always_comb begin
        o_push       = accept && i_in_data.last_block;
        o_job.bucket = sum[BUCKET_BITS-1:0];
        o_job.region = i_in_data.region_id;
        o_job.x      = i_in_data.x_coord;
        o_job.y      = i_in_data.y_coord;
        o_job.code   = n_code;
        o_job.flags  = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_flag <= '0;
            r_bc   <= '0;
        end else if (accept) begin
            if (i_in_data.last_block) begin
                r_code <= '0;
                r_flag <= '0;
                r_bc   <= '0;
            end else begin
                r_code <= n_code;
                r_flag <= n_flag;
                r_bc   <= r_bc + BC_W'(take);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wrdd_queue.sv =====
// Short job queue between the assembly front and the bucket update back.
`default_nettype none

module wrdd_queue
    import wrdd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_ready = int'(r_cnt) < QDEPTH;
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (int'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (int'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wrdd_back.sv =====
// Bucket lookup, stale entry handling, replacement and result register.
`default_nettype none

`include "windowed_read_duplicate_detector_defines.svh"

module wrdd_back
    import wrdd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    output logic      o_run,
    input  wire logic i_q_valid,
    input  wire t_job i_q_job,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    t_row                   r_mem [BUCKETS];
    t_row                   r_row;
    t_row                   wr_row;
    t_job                   r_job;
    logic [1:0]             r_state;
    logic [BUCKET_BITS-1:0] r_clr;
    logic [WAYS-1:0]        r_match, r_fc, n_match, n_fc;
    logic                   r_out_valid;
    t_out                   r_out;
    logic [COUNT_W-1:0]     r_reads, r_dups;
    logic                   we, wb_go, dup, ovf;
    logic [BUCKET_BITS-1:0] wa;
    logic [WAYS-1:0]        v1, v2;
    int                     tgt;
    logic [KW_W-1:0]        kw;

    function automatic logic older(input t_row row, input int a, input int b);
        return (row[a].age > row[b].age) || (row[a].age == row[b].age && a > b);
    endfunction

    assign kw          = eff_words(i_cfg.key_words);
    assign o_run       = r_state != S_CLR;
    assign o_q_pop     = r_state == S_IDLE && i_q_valid;
    assign wb_go       = r_state == S_WB && (!r_out_valid || i_out_ready);
    assign we          = r_state == S_CLR || wb_go;
    assign wa          = (r_state == S_CLR) ? r_clr : r_job.bucket;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [COORD_BITS:0]   dy;
        logic [COORD_BITS-1:0] dx;
        logic                  stale, same, keq;
        for (int i = 0; i < WAYS; i++) begin
            dy    = {1'b0, r_job.y} - {1'b0, r_row[i].y};
            stale = !dy[COORD_BITS] && (dy[COORD_BITS-1:0] > i_cfg.window_y);
            same  = r_row[i].region == r_job.region;
            dx    = (r_row[i].x >= r_job.x) ? r_row[i].x - r_job.x : r_job.x - r_row[i].x;
            keq   = 1'b1;
            for (int j = 0; j < MAX_KEY_WORDS; j++) begin
                if (j < int'(kw) && r_row[i].code[j] != r_job.code[j]) begin
                    keq = 1'b0;
                end
            end
            for (int j = 0; j < UNK_WORDS; j++) begin
                if (j < (int'(kw) + 1) / 2 && r_row[i].flags[j] != r_job.flags[j]) begin
                    keq = 1'b0;
                end
            end
            n_match[i] = r_row[i].valid && !stale && same && (dx < i_cfg.window_x) && keq;
            n_fc[i]    = r_row[i].valid && (stale ? (i_cfg.order_mode == ORDER_SORTED)
                         : (!same && (i_cfg.order_mode == ORDER_SORTED
                                      || i_cfg.order_mode == ORDER_REGION)));
        end
    end

    always_comb begin
        logic             blocked;
        logic [AGE_W-1:0] rank;
        dup = |r_match;
        for (int i = 0; i < WAYS; i++) begin
            blocked = 1'b0;
            for (int j = 0; j < WAYS; j++) begin
                if (r_match[j] && older(r_row, j, i)) begin
                    blocked = 1'b1;
                end
            end
            v1[i] = r_row[i].valid && !(r_fc[i] && !blocked);
        end
        tgt = WAYS;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!v1[i]) begin
                tgt = i;
            end
        end
        ovf = tgt == WAYS;
        if (ovf) begin
            tgt = 0;
            for (int i = 1; i < WAYS; i++) begin
                if (older(r_row, i, tgt)) begin
                    tgt = i;
                end
            end
        end
        v2 = v1;
        v2[tgt] = 1'b0;
        wr_row = r_row;
        for (int i = 0; i < WAYS; i++) begin
            rank = '0;
            for (int j = 0; j < WAYS; j++) begin
                if (j != i && v2[j] && older(r_row, i, j)) begin
                    rank = rank + 1'b1;
                end
            end
            wr_row[i].valid = v2[i];
            if (v2[i]) begin
                wr_row[i].age = rank + 1'b1;
            end
        end
        wr_row[tgt].valid  = 1'b1;
        wr_row[tgt].age    = '0;
        wr_row[tgt].region = r_job.region;
        wr_row[tgt].x      = r_job.x;
        wr_row[tgt].y      = r_job.y;
        wr_row[tgt].code   = r_job.code;
        wr_row[tgt].flags  = r_job.flags;
        if (r_state == S_CLR) begin
            wr_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_row <= r_mem[i_q_job.bucket];
            r_job <= i_q_job;
        end
        if (r_state == S_CMP) begin
            r_match <= n_match;
            r_fc    <= n_fc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_reads     <= '0;
            r_dups      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_go) begin
                        r_out_valid               <= 1'b1;
                        r_out.duplicate_found     <= dup;
                        r_out.bucket_overflow     <= ovf;
                        r_out.read_total          <= (r_reads == '1) ? r_reads : r_reads + 1'b1;
                        r_out.duplicate_total     <= (dup && r_dups != '1) ? r_dups + 1'b1 : r_dups;
                        if (r_reads != '1) begin
                            r_reads <= r_reads + 1'b1;
                        end
                        if (dup && r_dups != '1) begin
                            r_dups <= r_dups + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

    `WRDD_ASSERT_IMPLIES(a_we_state, i_clk, i_rst_n, we, r_state == S_CLR || r_state == S_WB)
    `WRDD_ASSERT_NEXT(a_pop_to_cmp, i_clk, i_rst_n, o_q_pop, r_state == S_CMP)
    `WRDD_ASSERT_IMPLIES(a_out_from_wb, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_WB)
    `WRDD_ASSERT_IMPLIES(a_no_pop_clr, i_clk, i_rst_n, r_state == S_CLR, !o_q_pop && !o_out_valid)

endmodule

`default_nettype wire
